// ===== src/slcan_pkg.sv =====
// Shared types, character codes and helpers for the serial-line CAN command parser.
`default_nettype none

package slcan_pkg;

   localparam int LINE_LIMIT_DEFAULT = 64;
   localparam int MAX_DATA_BYTES     = 8;

   typedef enum logic [3:0] {
      KIND_FRAME    = 4'd0,
      KIND_STATUS   = 4'd1,
      KIND_OPEN     = 4'd2,
      KIND_CLOSE    = 4'd3,
      KIND_RATE_SET = 4'd4,
      KIND_HW_VER   = 4'd5,
      KIND_SW_VER   = 4'd6,
      KIND_ERROR    = 4'd7,
      KIND_OVERFLOW = 4'd8
   } kind_type;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_STD    = 8'h74;  // t
   localparam logic [7:0] CH_EXT    = 8'h54;  // T
   localparam logic [7:0] CH_STD_RM = 8'h72;  // r
   localparam logic [7:0] CH_EXT_RM = 8'h52;  // R
   localparam logic [7:0] CH_RATE   = 8'h53;  // S
   localparam logic [7:0] CH_STATUS = 8'h46;  // F
   localparam logic [7:0] CH_OPEN   = 8'h4F;  // O
   localparam logic [7:0] CH_CLOSE  = 8'h43;  // C
   localparam logic [7:0] CH_HW_VER = 8'h56;  // V
   localparam logic [7:0] CH_SW_VER = 8'h76;  // v
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_EIGHT  = 8'h38;

   localparam logic [7:0] STD_DIGITS     = 8'd3;
   localparam logic [7:0] EXT_DIGITS     = 8'd8;
   localparam logic [3:0] LEN_MAX        = 4'd8;
   localparam logic [3:0] BIT_RATE_RESET = 4'd4;
   localparam logic [28:0] STD_ID_MASK   = 29'h000007FF;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== src/slcan_command_parser.sv =====
// Top level of the serial-line CAN command parser: character in, decoded command out.
//
// Usage: req_ch carries one ASCII character per item on the req_ channel
// (req_valid / req_stall). A carriage return ends a command line and yields
// one item on the rsp_ channel (rsp_valid / rsp_stall) with the decoded kind,
// frame fields and rate index. Other characters yield no item, except the one
// that would fill the line to LINE_LIMIT characters: that line is dropped and
// an overflow item is sent.
// Path: a character is held in the input register from its accepting edge,
// and its result is then loaded into the result register; a stall can hold it
// in the input register first. Throughput: one character per cycle while
// req_stall is low, set by the single input-register-to-result-register pass.
// Stall: while rsp_stall holds a result, characters that produce no result
// keep flowing; a line end or overflow waits in the input register, and then
// req_stall rises.
// Reset: clears the line and both registers' valid flags; bit rate index
// returns to 4.
`default_nettype none

module slcan_command_parser #(
   parameter int LINE_LIMIT = slcan_pkg::LINE_LIMIT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_kind,
   output logic [28:0]      rsp_ident,
   output logic             rsp_extended,
   output logic             rsp_remote,
   output logic [3:0]       rsp_length_code,
   output logic [63:0]      rsp_payload,
   output logic [3:0]       rsp_rate_index
);

   localparam int POS_W = $clog2(LINE_LIMIT);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_LIMIT - 1);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_ch_ff, in_ch_in;
   logic [POS_W-1:0] line_pos_ff, line_pos_in;
   logic [7:0]       letter_ff, letter_in;
   logic [31:0]      ident_ff, ident_in;
   logic [3:0]       len_ff, len_in;
   logic [63:0]      data_ff, data_in;
   logic             rate_ok_ff, rate_ok_in;
   logic [3:0]       rate_val_ff, rate_val_in;
   logic [3:0]       bit_rate_ff, bit_rate_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       kind_ff, kind_in;
   logic [28:0]      ident_out_ff, ident_out_in;
   logic             ext_ff, ext_in;
   logic             rtr_ff, rtr_in;
   logic [3:0]       len_out_ff, len_out_in;
   logic [63:0]      data_out_ff, data_out_in;
   logic [3:0]       rate_out_ff, rate_out_in;

   logic             is_cr, is_over, has_result, step;
   logic             is_ext, is_rtr, is_frame;
   logic [7:0]       pos8, ndig, dig_rem, off;
   logic [3:0]       h;
   logic [4:0]       id_sh;
   logic [5:0]       pl_sh;
   logic             rate_take;

   assign is_cr      = (in_ch_ff == slcan_pkg::CH_CR);
   assign is_over    = !is_cr && (line_pos_ff == POS_LAST);
   assign has_result = is_cr || is_over;
   assign step       = in_valid_ff && (!has_result || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !step;

   assign is_ext   = (letter_ff == slcan_pkg::CH_EXT) || (letter_ff == slcan_pkg::CH_EXT_RM);
   assign is_rtr   = (letter_ff == slcan_pkg::CH_STD_RM) || (letter_ff == slcan_pkg::CH_EXT_RM);
   assign is_frame = is_ext || is_rtr || (letter_ff == slcan_pkg::CH_STD);
   assign pos8     = 8'(line_pos_ff);
   assign ndig     = is_ext ? slcan_pkg::EXT_DIGITS : slcan_pkg::STD_DIGITS;
   assign dig_rem  = ndig - pos8;
   assign off      = pos8 - ndig - 8'd2;
   assign h        = slcan_pkg::hex_value(in_ch_ff);
   assign id_sh    = {dig_rem[2:0], 2'b00};
   assign pl_sh    = {off[3:1], ~off[0], 2'b00};
   assign rate_take = is_cr && (letter_ff == slcan_pkg::CH_RATE) && (pos8 == 8'd2) && rate_ok_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_ch_in    = in_ch_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_ch_in    = req_ch;
      end
   end

   always_comb begin
      line_pos_in = line_pos_ff;
      letter_in   = letter_ff;
      ident_in    = ident_ff;
      len_in      = len_ff;
      data_in     = data_ff;
      rate_ok_in  = rate_ok_ff;
      rate_val_in = rate_val_ff;
      bit_rate_in = bit_rate_ff;
      if (step) begin
         if (has_result) begin
            line_pos_in = '0;
            letter_in   = '0;
            ident_in    = '0;
            len_in      = '0;
            data_in     = '0;
            rate_ok_in  = 1'b0;
            rate_val_in = '0;
            if (rate_take) begin
               bit_rate_in = rate_val_ff;
            end
         end else begin
            line_pos_in = line_pos_ff + POS_W'(1);
            if (pos8 == 8'd0) begin
               letter_in = in_ch_ff;
            end else if (is_frame) begin
               if (pos8 <= ndig) begin
                  ident_in = ident_ff | (32'(h) << id_sh);
               end else if (pos8 == ndig + 8'd1) begin
                  len_in = h;
               end else if (!is_rtr && off[7:4] == 4'd0) begin
                  data_in = data_ff | (64'(h) << pl_sh);
               end
            end else if (letter_ff == slcan_pkg::CH_RATE && pos8 == 8'd1) begin
               rate_ok_in  = (in_ch_ff >= slcan_pkg::CH_ZERO) && (in_ch_ff <= slcan_pkg::CH_EIGHT);
               rate_val_in = in_ch_ff[3:0];
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      ident_out_in = ident_out_ff;
      ext_in       = ext_ff;
      rtr_in       = rtr_ff;
      len_out_in   = len_out_ff;
      data_out_in  = data_out_ff;
      rate_out_in  = rate_out_ff;
      if (step && has_result) begin
         rsp_valid_in = 1'b1;
         kind_in      = slcan_pkg::KIND_ERROR;
         ident_out_in = '0;
         ext_in       = 1'b0;
         rtr_in       = 1'b0;
         len_out_in   = '0;
         data_out_in  = '0;
         rate_out_in  = '0;
         if (is_over) begin
            kind_in = slcan_pkg::KIND_OVERFLOW;
         end else if (pos8 == 8'd0) begin
            kind_in = slcan_pkg::KIND_ERROR;
         end else if (is_frame) begin
            if (len_ff <= slcan_pkg::LEN_MAX) begin
               kind_in      = slcan_pkg::KIND_FRAME;
               ident_out_in = is_ext ? ident_ff[28:0] : (ident_ff[28:0] & slcan_pkg::STD_ID_MASK);
               ext_in       = is_ext;
               rtr_in       = is_rtr;
               len_out_in   = len_ff;
               data_out_in  = is_rtr ? 64'd0 : data_ff;
            end
         end else if (letter_ff == slcan_pkg::CH_RATE) begin
            if (rate_take) begin
               kind_in     = slcan_pkg::KIND_RATE_SET;
               rate_out_in = rate_val_ff;
            end
         end else if (pos8 == 8'd1) begin
            case (letter_ff)
               slcan_pkg::CH_STATUS: kind_in = slcan_pkg::KIND_STATUS;
               slcan_pkg::CH_OPEN: begin
                  kind_in     = slcan_pkg::KIND_OPEN;
                  rate_out_in = bit_rate_ff;
               end
               slcan_pkg::CH_CLOSE:  kind_in = slcan_pkg::KIND_CLOSE;
               slcan_pkg::CH_HW_VER: kind_in = slcan_pkg::KIND_HW_VER;
               slcan_pkg::CH_SW_VER: kind_in = slcan_pkg::KIND_SW_VER;
               default:              kind_in = slcan_pkg::KIND_ERROR;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      in_ch_ff     <= in_ch_in;
      kind_ff      <= kind_in;
      ident_out_ff <= ident_out_in;
      ext_ff       <= ext_in;
      rtr_ff       <= rtr_in;
      len_out_ff   <= len_out_in;
      data_out_ff  <= data_out_in;
      rate_out_ff  <= rate_out_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         line_pos_ff  <= '0;
         letter_ff    <= '0;
         ident_ff     <= '0;
         len_ff       <= '0;
         data_ff      <= '0;
         rate_ok_ff   <= 1'b0;
         rate_val_ff  <= '0;
         bit_rate_ff  <= slcan_pkg::BIT_RATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         line_pos_ff  <= line_pos_in;
         letter_ff    <= letter_in;
         ident_ff     <= ident_in;
         len_ff       <= len_in;
         data_ff      <= data_in;
         rate_ok_ff   <= rate_ok_in;
         rate_val_ff  <= rate_val_in;
         bit_rate_ff  <= bit_rate_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_ident       = ident_out_ff;
   assign rsp_extended    = ext_ff;
   assign rsp_remote      = rtr_ff;
   assign rsp_length_code = len_out_ff;
   assign rsp_payload     = data_out_ff;
   assign rsp_rate_index  = rate_out_ff;

`ifndef SYNTHESIS
   a_frame_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == slcan_pkg::KIND_FRAME |-> len_out_ff <= slcan_pkg::LEN_MAX)
      else $error("frame item with length code above limit");
   a_nonframe_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != slcan_pkg::KIND_FRAME
      |-> ident_out_ff == '0 && data_out_ff == '0 && !ext_ff && !rtr_ff)
      else $error("non-frame item carries frame fields");
   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      bit_rate_ff <= slcan_pkg::LEN_MAX)
      else $error("bit rate index out of range");
   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      step && is_over |=> line_pos_ff == '0 && rsp_valid_ff)
      else $error("overflow did not restart the line");
`endif

endmodule

`default_nettype wire

// ===== bench/slcan_command_parser_tb.sv =====
// Self-checking testbench for the serial-line CAN command parser with a built-in line predictor.
`default_nettype none

module slcan_command_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import slcan_pkg::*;

   localparam int LINE_LIMIT  = slcan_pkg::LINE_LIMIT_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TOTAL_CHARS = 1500;

   typedef struct packed {
      logic [3:0]  kind;
      logic [28:0] ident;
      logic        extended;
      logic        remote;
      logic [3:0]  length_code;
      logic [63:0] payload;
      logic [3:0]  rate_index;
   } command_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_kind;
   logic [28:0] rsp_ident;
   logic        rsp_extended;
   logic        rsp_remote;
   logic [3:0]  rsp_length_code;
   logic [63:0] rsp_payload;
   logic [3:0]  rsp_rate_index;

   slcan_command_parser #(.LINE_LIMIT(LINE_LIMIT)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_ch(req_ch),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind), .rsp_ident(rsp_ident), .rsp_extended(rsp_extended),
      .rsp_remote(rsp_remote), .rsp_length_code(rsp_length_code),
      .rsp_payload(rsp_payload), .rsp_rate_index(rsp_rate_index)
   );

   logic [7:0]  char_feed[$];
   command_type expected_cmds[$];

   int accepted_chars = 0;
   int checked_cmds = 0;
   int frame_cmds = 0;
   int error_cmds = 0;
   int overflow_cmds = 0;
   int errors = 0;
   int cycles = 0;
   int gap_left = 0;
   int stall_hold = 0;
   logic calm;

   assign calm = ((accepted_chars >> 8) % 4) == 3;

   // predictor state
   int          line_len = 0;
   logic [7:0]  letter = 8'h00;
   logic [31:0] id_acc = '0;
   logic [3:0]  dlc_acc = '0;
   logic [63:0] data_acc = '0;
   logic        data_full = 1'b0;
   logic [7:0]  rate_ch = 8'h00;
   logic [3:0]  rate_idx = BIT_RATE_RESET;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      return 4'd0;
   endfunction

   function automatic logic is_frame(input logic [7:0] c);
      return c == CH_STD || c == CH_EXT || c == CH_STD_RM || c == CH_EXT_RM;
   endfunction

   task automatic clear_line();
      line_len = 0;
      letter = 8'h00;
      id_acc = '0;
      dlc_acc = '0;
      data_acc = '0;
      data_full = 1'b0;
      rate_ch = 8'h00;
   endtask

   task automatic store_char(input logic [7:0] c);
      int ndig;
      int off;
      int idx;
      logic rtr;
      logic [3:0] h;
      if (line_len == 0) begin
         letter = c;
      end else if (is_frame(letter)) begin
         ndig = (letter == CH_EXT || letter == CH_EXT_RM) ? 8 : 3;
         rtr = (letter == CH_STD_RM || letter == CH_EXT_RM);
         h = nibble_of(c);
         if (line_len <= ndig) begin
            id_acc = id_acc | ({28'd0, h} << (4 * (ndig - line_len)));
         end else if (line_len == ndig + 1) begin
            dlc_acc = h;
         end else if (!rtr && !data_full) begin
            off = line_len - ndig - 2;
            idx = off >> 1;
            if (idx < MAX_DATA_BYTES) begin
               if ((off & 1) == 0) begin
                  data_acc = data_acc | ({60'd0, h} << (8 * idx + 4));
               end else begin
                  data_acc = data_acc | ({60'd0, h} << (8 * idx));
                  if (idx == MAX_DATA_BYTES - 1) data_full = 1'b1;
               end
            end
         end
      end else if (letter == CH_RATE && line_len == 1) begin
         rate_ch = c;
      end
   endtask

   task automatic parse_char(input logic [7:0] c);
      command_type cmd;
      logic ext;
      logic rtr;
      cmd = '0;
      if (c != CH_CR) begin
         if (line_len + 1 >= LINE_LIMIT) begin
            cmd.kind = KIND_OVERFLOW;
            expected_cmds.push_back(cmd);
            clear_line();
         end else begin
            store_char(c);
            line_len = line_len + 1;
         end
      end else begin
         cmd.kind = KIND_ERROR;
         if (line_len == 0) begin
         end else if (is_frame(letter)) begin
            ext = (letter == CH_EXT || letter == CH_EXT_RM);
            rtr = (letter == CH_STD_RM || letter == CH_EXT_RM);
            if (dlc_acc <= LEN_MAX) begin
               cmd.kind = KIND_FRAME;
               cmd.ident = ext ? id_acc[28:0] : (id_acc[28:0] & STD_ID_MASK);
               cmd.extended = ext;
               cmd.remote = rtr;
               cmd.length_code = dlc_acc;
               cmd.payload = rtr ? 64'd0 : data_acc;
            end
         end else if (letter == CH_RATE) begin
            if (line_len == 2 && rate_ch >= CH_ZERO && rate_ch <= CH_EIGHT) begin
               rate_idx = 4'(rate_ch - CH_ZERO);
               cmd.kind = KIND_RATE_SET;
               cmd.rate_index = rate_idx;
            end
         end else if (line_len == 1) begin
            case (letter)
               CH_STATUS: cmd.kind = KIND_STATUS;
               CH_OPEN: begin
                  cmd.kind = KIND_OPEN;
                  cmd.rate_index = rate_idx;
               end
               CH_CLOSE:  cmd.kind = KIND_CLOSE;
               CH_HW_VER: cmd.kind = KIND_HW_VER;
               CH_SW_VER: cmd.kind = KIND_SW_VER;
               default: ;
            endcase
         end
         expected_cmds.push_back(cmd);
         clear_line();
      end
   endtask

   function automatic logic [7:0] hex_char();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return 8'(CH_ZERO + r);
      if (r < 16) return 8'("a" + r - 10);
      return 8'("A" + r - 16);
   endfunction

   function automatic logic [7:0] digit_char();
      if ($urandom_range(0, 19) == 0) return 8'($urandom_range(8'h67, 8'h7E));
      return hex_char();
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == CH_CR) c = 8'h8D;
      return c;
   endfunction

   task automatic push_line(input string s);
      for (int i = 0; i < s.len(); i++) char_feed.push_back(s[i]);
      char_feed.push_back(CH_CR);
   endtask

   task automatic push_run(input logic [7:0] c, input int n);
      for (int i = 0; i < n; i++) char_feed.push_back(c);
   endtask

   task automatic random_line();
      logic [7:0] line_buf[0:127];
      logic [7:0] frame_letters[4];
      logic [7:0] plain_letters[5];
      int n;
      int w;
      int ndig;
      int dlc;
      int keep;
      n = 0;
      frame_letters = '{CH_STD, CH_EXT, CH_STD_RM, CH_EXT_RM};
      plain_letters = '{CH_STATUS, CH_OPEN, CH_CLOSE, CH_HW_VER, CH_SW_VER};
      w = $urandom_range(0, 99);
      if (w < 60) begin
         line_buf[n++] = frame_letters[$urandom_range(0, 3)];
         ndig = (line_buf[0] == CH_EXT || line_buf[0] == CH_EXT_RM) ? 8 : 3;
         for (int i = 0; i < ndig; i++) line_buf[n++] = digit_char();
         dlc = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 15);
         line_buf[n++] = (dlc < 10) ? 8'(CH_ZERO + dlc) : 8'("A" + dlc - 10);
         if (dlc > 8) dlc = $urandom_range(0, 8);
         for (int i = 0; i < 2 * dlc; i++) line_buf[n++] = digit_char();
         if ($urandom_range(0, 9) == 0) begin
            for (int i = $urandom_range(1, 20); i > 0; i--) line_buf[n++] = digit_char();
         end
         if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
      end else if (w < 75) begin
         line_buf[n++] = plain_letters[$urandom_range(0, 4)];
         if ($urandom_range(0, 9) == 0) line_buf[n++] = noise_char();
      end else if (w < 85) begin
         line_buf[n++] = CH_RATE;
         if ($urandom_range(0, 19) != 0) line_buf[n++] = 8'(CH_ZERO + $urandom_range(0, 9));
         if ($urandom_range(0, 9) == 0) line_buf[n++] = noise_char();
      end else if (w < 96) begin
         for (int i = $urandom_range(0, 8); i > 0; i--) line_buf[n++] = noise_char();
      end else begin
         for (int i = $urandom_range(LINE_LIMIT - 4, LINE_LIMIT + 8); i > 0; i--) begin
            line_buf[n++] = noise_char();
         end
      end
      keep = ($urandom_range(0, 19) == 0) ? 0 : 1;
      for (int i = 0; i < n; i++) char_feed.push_back(line_buf[i]);
      if (keep) char_feed.push_back(CH_CR);
   endtask

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_char(req_ch);
            accepted_chars = accepted_chars + 1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (char_feed.size() > 0) begin
               req_ch <= char_feed.pop_front();
               req_valid <= 1'b1;
               gap_left = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : stall_gen
      int r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold = stall_hold - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (calm || r < 55) begin
            rsp_stall <= 1'b0;
            stall_hold = $urandom_range(0, 6);
         end else if (r < 92) begin
            rsp_stall <= 1'b1;
            stall_hold = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_hold = $urandom_range(10, 50);
         end
      end
   end

   always @(posedge clock) begin : result_check
      command_type got;
      command_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_kind, rsp_ident, rsp_extended, rsp_remote, rsp_length_code,
                rsp_payload, rsp_rate_index};
         checked_cmds = checked_cmds + 1;
         if (got.kind == KIND_FRAME) frame_cmds = frame_cmds + 1;
         if (got.kind == KIND_ERROR) error_cmds = error_cmds + 1;
         if (got.kind == KIND_OVERFLOW) overflow_cmds = overflow_cmds + 1;
         if (expected_cmds.size() == 0) begin
            errors = errors + 1;
            if (errors <= 10) $display("unexpected result: kind %0d ident %h", got.kind,
                                       got.ident);
         end else begin
            want = expected_cmds.pop_front();
            if (got.kind !== want.kind || got.ident !== want.ident ||
                got.extended !== want.extended || got.remote !== want.remote ||
                got.length_code !== want.length_code || got.payload !== want.payload ||
                got.rate_index !== want.rate_index) begin
               errors = errors + 1;
               if (errors <= 10) begin
                  $display("mismatch: expected kind %0d id %h ext %b rtr %b dlc %0d data %h rate %0d",
                           want.kind, want.ident, want.extended, want.remote,
                           want.length_code, want.payload, want.rate_index);
                  $display("          actual   kind %0d id %h ext %b rtr %b dlc %0d data %h rate %0d",
                           got.kind, got.ident, got.extended, got.remote,
                           got.length_code, got.payload, got.rate_index);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      push_line("t7FF8FFFFFFFFFFFFFFFF");
      push_line("t0000");
      push_line("T1FFFFFFF80123456789abcdef");
      push_line("TFFFFFFFF0");
      push_line("r1234");
      push_line("R000000018deadbeef");
      push_line("t1239");
      push_line("t12");
      push_line("tXYZ8GGhh");
      push_line("t5A58aAbBcCdDeEfF0011223344");
      push_line("F");
      push_line("O");
      push_line("C");
      push_line("V");
      push_line("v");
      push_line("FX");
      push_line("S8");
      push_line("O");
      push_line("S0");
      push_line("S9");
      push_line("S");
      push_line("S12");
      push_line("");
      push_line("Q");
      push_run("A", LINE_LIMIT + 6);
      push_line("");
      char_feed.push_back(CH_STD);
      push_run("1", LINE_LIMIT - 2);
      push_line("");
      while (char_feed.size() < TOTAL_CHARS) random_line();
      push_line("S4");

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (char_feed.size() != 0 || req_valid || expected_cmds.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("%0d characters sent, %0d commands checked", accepted_chars, checked_cmds);
      $display("%0d frames, %0d errors, %0d overflows among them", frame_cmds, error_cmds,
               overflow_cmds);
      if (errors == 0 && expected_cmds.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
